// ----- rtl/core/linear_probe_hash_table_defines.svh -----
// assertion helpers shared by the hash table rtl
// every macro samples on clk and is disabled while rst_n is low
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht assertion failed");

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht assertion failed");

`endif

// ----- rtl/core/lpht_pkg.sv -----
package lpht_pkg;

  localparam int HASH_W  = 32;
  localparam int VAL_W   = 32;
  localparam int TAKEN_W = 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ITER   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [HASH_W-1:0] key_hash;
    logic [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   result_value;
    logic [HASH_W-1:0]  result_key_hash;
    logic [TAKEN_W-1:0] slots_taken;
  } out_item_t;

endpackage

// ----- rtl/core/lpht_home_unit.sv -----
module lpht_home_unit #(
  parameter int SLOTS = 16,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lpht_pkg::HASH_W-1:0] hash,
  output logic                      done,
  output logic [IDX_W-1:0]          home
);
  import lpht_pkg::*;

  localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  // reciprocal of SLOTS scaled by 2^SHIFT and rounded up, exact for any 32-bit hash
  localparam int SHIFT = HASH_W + IDX_W;
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(SLOTS - 1)) / 64'(SLOTS);
  localparam logic [HASH_W-1:0] RECIP_LO = RECIP[HASH_W-1:0];
  localparam bit RECIP_HI = RECIP[HASH_W];
  localparam logic [IDX_W-1:0] SLOTS_LO = IDX_W'(SLOTS);

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_QUOT,
    H_REM
  } hstate_t;

  hstate_t           state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [HASH_W-1:0] x_r, x_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [IDX_W-1:0]  qlo_r, qlo_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [63:0]       sum;
  logic [IDX_W-1:0]  q_times_s;

  // upper reciprocal bit folded into the product, low quotient bits times SLOTS
  always_comb begin
    sum       = prod_r + (RECIP_HI ? {x_r, {HASH_W{1'b0}}} : 64'd0);
    q_times_s = qlo_r * SLOTS_LO;
  end

  // power-of-two table takes the low bits, otherwise multiply, quotient, remainder
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    prod_nxt  = prod_r;
    qlo_nxt   = qlo_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          if (IS_POW2) begin
            rem_nxt  = hash[IDX_W-1:0];
            done_nxt = 1'b1;
          end else begin
            x_nxt     = hash;
            state_nxt = H_MUL;
          end
        end
      end
      H_MUL: begin
        prod_nxt  = 64'(x_r) * 64'(RECIP_LO);
        state_nxt = H_QUOT;
      end
      H_QUOT: begin
        qlo_nxt   = sum[SHIFT +: IDX_W];
        state_nxt = H_REM;
      end
      H_REM: begin
        // remainder fits in the low bits, so only those are formed
        rem_nxt   = x_r[IDX_W-1:0] - q_times_s;
        done_nxt  = 1'b1;
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      x_r     <= x_nxt;
      prod_r  <= prod_nxt;
      qlo_r   <= qlo_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// sequencing: get, set and delete pass S_HOME, S_RD, S_CHK and S_OUT when the first
//   probed slot decides (iterate skips S_HOME), plus S_RD and S_CHK per further probe;
//   a SLOTS not a power of two adds H_MUL, H_QUOT and H_REM for the home slot remainder
// throughput: one item at a time; in_stall is high outside S_IDLE and out_stall can hold
//   an item in S_OUT; the next item is accepted once the result is registered
// reset: after rst_n rises, S_CLEAR writes every slot empty before the first item is taken
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table #(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpht_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpht_pkg::out_item_t  out_data
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MEM_W = 1 + HASH_W + VAL_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_RD,
    S_CHK,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  probe_r, probe_nxt;
  logic [CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  status_t           status_r, status_nxt;
  logic [VAL_W-1:0]  rval_r, rval_nxt;
  logic [HASH_W-1:0] rkey_r, rkey_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // slot memory: {allocated, hash, value}
  logic [MEM_W-1:0]  slot_mem [SLOTS];
  logic [MEM_W-1:0]  rd_q;
  logic              mem_we;
  logic [MEM_W-1:0]  mem_wdata;
  logic              rd_alloc;
  logic [HASH_W-1:0] rd_hash;
  logic [VAL_W-1:0]  rd_val;

  logic              home_start;
  logic              home_done;
  logic [IDX_W-1:0]  home_idx;
  logic [IDX_W-1:0]  idx_wrap;
  logic              exhausted;
  logic              out_free;
  logic [CNT_W+TAKEN_W-1:0] taken_ext;

  lpht_home_unit #(.SLOTS(SLOTS)) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .hash  (in_data.key_hash),
    .done  (home_done),
    .home  (home_idx)
  );

  assign rd_alloc  = rd_q[MEM_W-1];
  assign rd_hash   = rd_q[HASH_W+VAL_W-1:VAL_W];
  assign rd_val    = rd_q[VAL_W-1:0];
  assign idx_wrap  = (idx_r == LAST_IDX) ? '0 : (idx_r + 1'b1);
  assign exhausted = (probe_r == LAST_CNT);
  assign out_free  = !out_valid_r || !out_stall;
  assign taken_ext = (CNT_W + TAKEN_W)'(count_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    hash_nxt      = hash_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    rval_nxt      = rval_r;
    rkey_nxt      = rkey_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = {1'b1, hash_r, val_r};
    home_start    = 1'b0;
    case (state_r)
      // empty every slot after reset
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        idx_nxt   = idx_wrap;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      // take an item and screen the trivial cases
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.command;
          hash_nxt   = in_data.key_hash;
          val_nxt    = in_data.value;
          status_nxt = ST_NOTFOUND;
          rval_nxt   = '0;
          rkey_nxt   = '0;
          probe_nxt  = '0;
          case (in_data.command)
            CMD_GET, CMD_DELETE: begin
              if (in_data.key_hash == '0) begin
                state_nxt = S_OUT;
              end else begin
                home_start = 1'b1;
                state_nxt  = S_HOME;
              end
            end
            CMD_SET: begin
              if ((in_data.key_hash == '0) || (in_data.value == '0)) begin
                status_nxt = ST_REJECTED;
                state_nxt  = S_OUT;
              end else begin
                home_start = 1'b1;
                state_nxt  = S_HOME;
              end
            end
            CMD_ITER: begin
              if (cursor_r >= SLOTS_CNT) begin
                cursor_nxt = '0;
                state_nxt  = S_OUT;
              end else begin
                idx_nxt   = cursor_r[IDX_W-1:0];
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      // wait for the home slot
      S_HOME: begin
        if (home_done) begin
          idx_nxt   = home_idx;
          state_nxt = S_RD;
        end
      end
      // slot read in flight
      S_RD: begin
        state_nxt = S_CHK;
      end
      // decide on the slot just read
      S_CHK: begin
        probe_nxt = probe_r + 1'b1;
        case (cmd_r)
          CMD_GET, CMD_DELETE: begin
            if (!rd_alloc) begin
              state_nxt = S_OUT;
            end else if (rd_hash == hash_r) begin
              status_nxt = ST_FOUND;
              rval_nxt   = rd_val;
              state_nxt  = S_OUT;
              if (cmd_r == CMD_DELETE) begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, {HASH_W{1'b0}}, rd_val};
              end
            end else if (exhausted) begin
              state_nxt = S_OUT;
            end else begin
              idx_nxt   = idx_wrap;
              state_nxt = S_RD;
            end
          end
          CMD_SET: begin
            if (!rd_alloc) begin
              mem_we     = 1'b1;
              count_nxt  = count_r + 1'b1;
              status_nxt = ST_INSERTED;
              state_nxt  = S_OUT;
            end else if (rd_hash == '0) begin
              mem_we     = 1'b1;
              status_nxt = ST_INSERTED;
              state_nxt  = S_OUT;
            end else if (rd_hash == hash_r) begin
              mem_we     = 1'b1;
              rval_nxt   = rd_val;
              status_nxt = ST_FOUND;
              state_nxt  = S_OUT;
            end else if (exhausted) begin
              status_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else begin
              idx_nxt   = idx_wrap;
              state_nxt = S_RD;
            end
          end
          default: begin
            // iterate: live slot ends the walk, the last slot wraps the cursor
            cursor_nxt = cursor_r + 1'b1;
            if (rd_alloc && (rd_hash != '0)) begin
              status_nxt = ST_FOUND;
              rval_nxt   = rd_val;
              rkey_nxt   = rd_hash;
              state_nxt  = S_OUT;
            end else if (cursor_r == LAST_CNT) begin
              cursor_nxt = '0;
              state_nxt  = S_OUT;
            end else begin
              idx_nxt   = idx_wrap;
              state_nxt = S_RD;
            end
          end
        endcase
      end
      // hand the result to the output register
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = status_r;
          out_data_nxt.result_value    = rval_r;
          out_data_nxt.result_key_hash = rkey_r;
          out_data_nxt.slots_taken     = taken_ext[TAKEN_W-1:0];
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cursor_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      hash_r      <= hash_nxt;
      val_r       <= val_nxt;
      idx_r       <= idx_nxt;
      probe_r     <= probe_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      rval_r      <= rval_nxt;
      rkey_r      <= rkey_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[idx_r] <= mem_wdata;
    end
    rd_q <= slot_mem[idx_r];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LPHT_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= SLOTS_CNT)
  `LPHT_ASSERT_IMPL(a_cursor_bound, 1'b1, cursor_r <= SLOTS_CNT)
  `LPHT_ASSERT_IMPL(a_we_state, mem_we, (state_r == S_CHK) || (state_r == S_CLEAR))
  `LPHT_ASSERT_IMPL(a_count_step, count_r != $past(count_r),
                    (count_r == ($past(count_r) + 1'b1)) && ($past(state_r) == S_CHK) &&
                    ($past(cmd_r) == CMD_SET))
  `LPHT_ASSERT_NEXT(a_out_load, (state_r == S_OUT) && out_free,
                    out_valid_r && (state_r == S_IDLE))

endmodule
